// File: hdl/mie_pkg.sv
// Shared constants and types for the modular inverse unit.
// No dependencies; imported by the divider step unit and the top level.
package mie_pkg;

  localparam int DATA_BITS = 64;
  localparam int WORD_BITS = 64;
  localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

  typedef logic [DATA_BITS-1:0] data_t;
  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

endpackage

// File: hdl/mie_div.sv
// Bit-serial restoring divider with a running quotient-times-coefficient product.
// One quotient bit per cycle; depends on mie_pkg.
module mie_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  mie_pkg::word_t dividend,
  input  mie_pkg::word_t divisor,
  input  mie_pkg::word_t coef,
  output logic           done,
  output mie_pkg::word_t remainder,
  output mie_pkg::word_t product
);
  import mie_pkg::*;

  logic             running;
  cnt_t             cnt;
  word_t            rem;
  word_t            quo;
  word_t            acc;
  logic [WORD_BITS:0] partial;
  logic [WORD_BITS:0] diff;
  logic             qbit;
  word_t            rem_next;
  word_t            acc_next;

  always_comb begin
    partial  = {rem, quo[WORD_BITS-1]};
    diff     = partial - {1'b0, divisor};
    qbit     = ~diff[WORD_BITS];
    rem_next = qbit ? diff[WORD_BITS-1:0] : partial[WORD_BITS-1:0];
    acc_next = {acc[WORD_BITS-2:0], 1'b0} + (qbit ? coef : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(WORD_BITS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      acc <= '0;
    end else if (running) begin
      rem <= rem_next;
      quo <= {quo[WORD_BITS-2:0], qbit};
      acc <= acc_next;
    end
  end

  assign remainder = rem;
  assign product   = acc;

endmodule

// File: hdl/modular_inverse_euclid_unit.sv
// Top level of the extended Euclidean modular inverse unit.
// Sequences Euclid rounds over the shared divider mie_div; depends on mie_pkg.
//
// Usage:
//   A request is taken on the rising edge where start is high and busy is low;
//   value and modulus are sampled then. busy stays high until the result is out.
//   The result appears on coefficient and not_invertible for exactly one cycle
//   with done high; the receiver cannot stall, so it must take it then.
// Sequence:
//   A zero value finishes without a Euclid round (coefficient 0, not_invertible 1).
//   Otherwise each Euclid round is a load state (S_LOAD), WORD_BITS divider
//   steps at one quotient bit per cycle, and one update of the remainders and
//   coefficients when the divider reports done. Rounds repeat until the
//   remainder is zero; at 64 bits there are up to about 93 rounds.
// Throughput: one request at a time; the next may be taken while done is high.
// Reset: rst (synchronous) returns the sequencer to idle and drops done.
// The returned coefficient is unreduced and may be a negative two's-complement.
module modular_inverse_euclid_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  mie_pkg::data_t value,
  input  mie_pkg::data_t modulus,
  output logic           done,
  output mie_pkg::data_t coefficient,
  output logic           not_invertible
);
  import mie_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0] state;
  word_t      ra;
  word_t      rb;
  word_t      ta;
  word_t      tb;
  word_t      x_in;
  logic       div_start;
  logic       div_done;
  word_t      div_rem;
  word_t      div_prod;
  word_t      tb_next;

  assign x_in      = value[WORD_BITS-1:0];
  assign div_start = (state == S_LOAD);
  assign busy      = (state != S_IDLE);
  assign tb_next   = ta - div_prod;

  mie_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (ra),
    .divisor   (rb),
    .coef      (tb),
    .done      (div_done),
    .remainder (div_rem),
    .product   (div_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (x_in == '0) begin
              done <= 1'b1;
            end else begin
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (div_rem == '0) begin
              state <= S_IDLE;
              done  <= 1'b1;
            end else begin
              state <= S_LOAD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          ra             <= modulus[WORD_BITS-1:0];
          rb             <= x_in;
          ta             <= '0;
          tb             <= WORD_BITS'(1);
          coefficient    <= '0;
          not_invertible <= 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          ra             <= rb;
          rb             <= div_rem;
          ta             <= tb;
          tb             <= tb_next;
          coefficient    <= DATA_BITS'(tb);
          not_invertible <= (rb != WORD_BITS'(1));
        end
      end
      default: begin
      end
    endcase
  end

endmodule
